FILE: design/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the region change detector.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // field widths
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int COUNT_W  = 18;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_LEFT       = 3'd0;
  localparam logic [2:0] REG_TOP        = 3'd1;
  localparam logic [2:0] REG_WIDTH      = 3'd2;
  localparam logic [2:0] REG_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_CHAN_THR   = 3'd4;
  localparam logic [2:0] REG_COUNT_THR  = 3'd5;

  // reset values
  localparam logic [COORD_W-1:0] LEFT_RST      = 12'd13;
  localparam logic [COORD_W-1:0] TOP_RST       = 12'd152;
  localparam logic [SIZE_W-1:0]  WIDTH_RST     = 13'd220;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST    = 13'd33;
  localparam logic [CHAN_W-1:0]  CHAN_THR_RST  = 8'd50;
  localparam logic [COUNT_W-1:0] COUNT_THR_RST = 18'd300;

  // configuration seen by the datapath
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [CHAN_W-1:0]  chan_thr;
    logic [COUNT_W-1:0] count_thr;
  } cfg_t;

endpackage

FILE: design/rcd_ram.sv
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module rcd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // old contents come out when the same address is written
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rcd_regs.sv
// ----------------------------------------------------------------------------
// rcd_regs
// APB-style register file holding the region and threshold settings.
// ----------------------------------------------------------------------------
module rcd_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rcd_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [rcd_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [rcd_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output rcd_pkg::cfg_t                 cfg
);

  rcd_pkg::cfg_t cfg_r;
  rcd_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        rcd_pkg::REG_LEFT:      cfg_nxt.left      = cfg_pwdata[rcd_pkg::COORD_W-1:0];
        rcd_pkg::REG_TOP:       cfg_nxt.top       = cfg_pwdata[rcd_pkg::COORD_W-1:0];
        rcd_pkg::REG_WIDTH:     cfg_nxt.width     = cfg_pwdata[rcd_pkg::SIZE_W-1:0];
        rcd_pkg::REG_HEIGHT:    cfg_nxt.height    = cfg_pwdata[rcd_pkg::SIZE_W-1:0];
        rcd_pkg::REG_CHAN_THR:  cfg_nxt.chan_thr  = cfg_pwdata[rcd_pkg::CHAN_W-1:0];
        rcd_pkg::REG_COUNT_THR: cfg_nxt.count_thr = cfg_pwdata[rcd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left      <= rcd_pkg::LEFT_RST;
      cfg_r.top       <= rcd_pkg::TOP_RST;
      cfg_r.width     <= rcd_pkg::WIDTH_RST;
      cfg_r.height    <= rcd_pkg::HEIGHT_RST;
      cfg_r.chan_thr  <= rcd_pkg::CHAN_THR_RST;
      cfg_r.count_thr <= rcd_pkg::COUNT_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    cfg_prdata = '0;
    case (idx)
      rcd_pkg::REG_LEFT:      cfg_prdata = rcd_pkg::DATA_W'(cfg_r.left);
      rcd_pkg::REG_TOP:       cfg_prdata = rcd_pkg::DATA_W'(cfg_r.top);
      rcd_pkg::REG_WIDTH:     cfg_prdata = rcd_pkg::DATA_W'(cfg_r.width);
      rcd_pkg::REG_HEIGHT:    cfg_prdata = rcd_pkg::DATA_W'(cfg_r.height);
      rcd_pkg::REG_CHAN_THR:  cfg_prdata = rcd_pkg::DATA_W'(cfg_r.chan_thr);
      rcd_pkg::REG_COUNT_THR: cfg_prdata = rcd_pkg::DATA_W'(cfg_r.count_thr);
      default:                cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: design/region_change_detector_unit.sv
// ----------------------------------------------------------------------------
// region_change_detector_unit
// Frame-difference change detection over a rectangular pixel region.
// ----------------------------------------------------------------------------
// Throughput: one pixel beat per clock; a frame-end beat holds the input only
//   while the previous verdict still waits unaccepted on the result side.
//   The reference RAM is read and written at the same address in the accept
//   cycle (read-first), so no interlock.
// Result path: an accepted frame-end beat is registered into stage 1, whose verdict
//   is then registered into out_tvalid and out_tdata.
// Reset: clears counters, offsets and the RAM fill count; no clearing pass,
//   entries at or above the fill count read as zero.
module region_change_detector_unit #(
  parameter int STORE_DEPTH = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [31:24] red, [39:32] green, [47:40] blue
  input  logic [rcd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,   // frame_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] region_changed, [18:1] changed_total, [23:19] zero
  output logic [rcd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rcd_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [rcd_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [rcd_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int OW = $clog2(STORE_DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_V = OW'(STORE_DEPTH);

  localparam int CW = rcd_pkg::COORD_W;
  localparam int HW = rcd_pkg::CHAN_W;
  localparam int PW = rcd_pkg::PIX_W;
  localparam int NW = rcd_pkg::COUNT_W;
  localparam int OUT_DATA_W_L = rcd_pkg::OUT_DATA_W;

  rcd_pkg::cfg_t cfg;

  rcd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // ---------------------------------------------------------------- stage 0
  logic [CW-1:0] px_x, px_y;
  logic [PW-1:0] px_rgb;
  logic          in_fire;
  logic          in_region, store_ok;
  logic [CW+1:0] x_end, y_end;

  assign px_x   = in_tdata[11:0];
  assign px_y   = in_tdata[23:12];
  assign px_rgb = {in_tdata[31:24], in_tdata[39:32], in_tdata[47:40]};
  assign in_fire = in_tvalid && in_tready;

  // region test, sums kept wide so they never wrap
  assign x_end  = {2'b00, cfg.left} + {1'b0, cfg.width};
  assign y_end  = {2'b00, cfg.top}  + {1'b0, cfg.height};
  assign in_region = (px_x >= cfg.left) && ({2'b00, px_x} < x_end) &&
                     (px_y >= cfg.top)  && ({2'b00, px_y} < y_end);

  logic [OW-1:0] off_r, off_nxt;
  logic [OW-1:0] fill_r, fill_nxt;

  assign store_ok = in_region && (off_r < DEPTH_V);

  // offset and high-water mark of written entries
  always_comb begin
    off_nxt  = off_r;
    fill_nxt = fill_r;
    if (in_fire) begin
      if (store_ok && (off_r == fill_r)) begin
        fill_nxt = fill_r + OW'(1);
      end
      if (in_tlast) begin
        off_nxt = '0;
      end else if (store_ok) begin
        off_nxt = off_r + OW'(1);
      end
    end
  end

  logic [PW-1:0] ram_rdata;

  rcd_ram #(
    .WIDTH (PW),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (in_fire && store_ok),
    .we    (in_fire && store_ok),
    .addr  (off_r[AW-1:0]),
    .wdata (px_rgb),
    .rdata (ram_rdata)
  );

  // stage 0 -> 1 registers
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_cmp_r;
  logic          s1_old_ok_r;
  logic          s1_last_r;
  logic [PW-1:0] s1_pix_r;

  // ---------------------------------------------------------------- stage 1
  logic          s1_go;
  logic [PW-1:0] old_pix;
  logic [HW-1:0] d_r, d_g, d_b;
  logic          changed;
  logic [NW-1:0] cnt_r, cnt_nxt, cnt_sum;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W_L-1:0] out_data_r, out_data_nxt;

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  assign old_pix = s1_old_ok_r ? ram_rdata : '0;

  // per-channel absolute differences
  function automatic logic [rcd_pkg::CHAN_W-1:0] abs_diff(
    input logic [rcd_pkg::CHAN_W-1:0] a,
    input logic [rcd_pkg::CHAN_W-1:0] b
  );
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign d_r = abs_diff(old_pix[PW-1 -: HW],   s1_pix_r[PW-1 -: HW]);
  assign d_g = abs_diff(old_pix[2*HW-1 -: HW], s1_pix_r[2*HW-1 -: HW]);
  assign d_b = abs_diff(old_pix[HW-1:0],       s1_pix_r[HW-1:0]);

  assign changed = s1_cmp_r &&
                   ((d_r > cfg.chan_thr) || (d_g > cfg.chan_thr) ||
                    (d_b > cfg.chan_thr));

  // saturating count
  assign cnt_sum = (changed && (cnt_r != rcd_pkg::COUNT_MAX)) ? cnt_r + NW'(1) : cnt_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      if (s1_last_r) begin
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = OUT_DATA_W_L'({cnt_sum, (cnt_sum > cfg.count_thr)});
      end else begin
        cnt_nxt = cnt_sum;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      off_r       <= off_nxt;
      fill_r      <= fill_nxt;
      s1_valid_r  <= s1_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmp_r    <= store_ok;
      s1_old_ok_r <= off_r < fill_r;
      s1_last_r   <= in_tlast;
      s1_pix_r    <= px_rgb;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for region_change_detector_unit. Pixel beats are
// driven in bursts with random gaps. A scoreboard keeps its own copy of the
// previous-frame store, the changed count and the region settings, and
// predicts the verdict for each frame. Verdict beats are checked field by
// field as the result side stalls on shifting patterns. Registers are
// programmed, and read back, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PIXEL_STORE_DEPTH = 8192;
  localparam int RANDOM_PIXELS     = 800;

  typedef struct packed {
    logic [rcd_pkg::COORD_W-1:0] x;
    logic [rcd_pkg::COORD_W-1:0] y;
    logic [rcd_pkg::CHAN_W-1:0]  r;
    logic [rcd_pkg::CHAN_W-1:0]  g;
    logic [rcd_pkg::CHAN_W-1:0]  b;
    logic                        last;
  } pixel_t;

  typedef struct packed {
    logic                        changed;
    logic [rcd_pkg::COUNT_W-1:0] total;
  } verdict_t;

  typedef enum logic [1:0] {
    ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, ALTERNATE
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Frame-difference scoreboard
  // --------------------------------------------------------------------------
  class frame_diff_scoreboard;
    logic [rcd_pkg::PIX_W-1:0] prev_frame [PIXEL_STORE_DEPTH];
    int unsigned left, top, width, height, chan_thr, count_thr;
    int unsigned changed_cnt, region_offset;
    verdict_t    expected_verdicts [$];
    int          mismatches;

    function new();
      foreach (prev_frame[i]) prev_frame[i] = '0;
      left        = rcd_pkg::LEFT_RST;
      top         = rcd_pkg::TOP_RST;
      width       = rcd_pkg::WIDTH_RST;
      height      = rcd_pkg::HEIGHT_RST;
      chan_thr    = rcd_pkg::CHAN_THR_RST;
      count_thr   = rcd_pkg::COUNT_THR_RST;
      changed_cnt   = 0;
      region_offset = 0;
      mismatches    = 0;
    endfunction

    // register write; returns the value a read should give back
    function logic [rcd_pkg::DATA_W-1:0] write_reg(logic [2:0] idx,
                                                   logic [rcd_pkg::DATA_W-1:0] value);
      case (idx)
        rcd_pkg::REG_LEFT: begin
          left = value[rcd_pkg::COORD_W-1:0];
          return left;
        end
        rcd_pkg::REG_TOP: begin
          top = value[rcd_pkg::COORD_W-1:0];
          return top;
        end
        rcd_pkg::REG_WIDTH: begin
          width = value[rcd_pkg::SIZE_W-1:0];
          return width;
        end
        rcd_pkg::REG_HEIGHT: begin
          height = value[rcd_pkg::SIZE_W-1:0];
          return height;
        end
        rcd_pkg::REG_CHAN_THR: begin
          chan_thr = value[rcd_pkg::CHAN_W-1:0];
          return chan_thr;
        end
        rcd_pkg::REG_COUNT_THR: begin
          count_thr = value[rcd_pkg::COUNT_W-1:0];
          return count_thr;
        end
        default: return '0;
      endcase
    endfunction

    function int unsigned chan_diff(logic [rcd_pkg::CHAN_W-1:0] a,
                                    logic [rcd_pkg::CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // accepted pixel beat: compare, update store, close frame on last
    function void note_pixel(pixel_t p);
      logic [rcd_pkg::PIX_W-1:0] old;
      bit                        in_region;
      verdict_t                  v;
      // sums in 32 bits, so no wrap at the far edge
      in_region = p.x >= left && p.x < left + width && p.y >= top && p.y < top + height;
      if (in_region && region_offset < PIXEL_STORE_DEPTH) begin
        old = prev_frame[region_offset];
        if (chan_diff(old[23:16], p.r) > chan_thr || chan_diff(old[15:8], p.g) > chan_thr ||
            chan_diff(old[7:0], p.b) > chan_thr) begin
          if (changed_cnt < rcd_pkg::COUNT_MAX) changed_cnt++;
        end
        prev_frame[region_offset] = {p.r, p.g, p.b};
        region_offset++;
      end
      if (p.last) begin
        v.changed = changed_cnt > count_thr;
        v.total   = changed_cnt[rcd_pkg::COUNT_W-1:0];
        expected_verdicts.push_back(v);
        changed_cnt   = 0;
        region_offset = 0;
      end
    endfunction

    function void flag(string what, logic [rcd_pkg::DATA_W-1:0] want,
                       logic [rcd_pkg::DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s differs: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // accepted verdict beat against the oldest prediction
    function void check_verdict(logic [rcd_pkg::OUT_DATA_W-1:0] beat);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        flag("unpredicted verdict beat", '0, beat);
        return;
      end
      want = expected_verdicts.pop_front();
      if (beat[0] !== want.changed) flag("region_changed", want.changed, beat[0]);
      if (beat[18:1] !== want.total) flag("changed_total", want.total, beat[18:1]);
      if (beat[23:19] !== '0) flag("verdict padding", '0, beat[23:19]);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and signals
  // --------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // [11:0] pixel_x, [23:12] pixel_y, [31:24] red, [39:32] green, [47:40] blue
  logic [rcd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tlast = 1'b0;   // frame_end
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [0] region_changed, [18:1] changed_total, [23:19] zero
  logic [rcd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [rcd_pkg::ADDR_W-1:0]     cfg_paddr = '0;
  logic [rcd_pkg::DATA_W-1:0]     cfg_pwdata = '0;
  logic [rcd_pkg::DATA_W-1:0]     cfg_prdata;
  logic                           cfg_pready;

  frame_diff_scoreboard sb = new();

  initial begin
    forever #1 clk = ~clk;
  end

  region_change_detector_unit #(.STORE_DEPTH(PIXEL_STORE_DEPTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Result side: one of four stall patterns on out_tready, each held for a random run of cycles
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = ALWAYS_READY;
  int          stall_left = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      ALWAYS_READY:   out_tready <= 1'b1;
      COIN_FLIP:      out_tready <= $urandom_range(0, 1);
      MOSTLY_STALLED: out_tready <= (stall_tick % 8) == 0;
      ALTERNATE:      out_tready <= stall_tick[0];
      default:        out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int random_pixels = 0;

  function automatic pixel_t px(int x, int y, int r, int g, int b, bit last);
    pixel_t p;
    p.x = rcd_pkg::COORD_W'(x);
    p.y = rcd_pkg::COORD_W'(y);
    p.r = rcd_pkg::CHAN_W'(r);
    p.g = rcd_pkg::CHAN_W'(g);
    p.b = rcd_pkg::CHAN_W'(b);
    p.last = last;
    return p;
  endfunction

  task automatic push_pixel(input pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {p.b, p.g, p.r, p.y, p.x};
    in_tlast  <= p.last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  // sender holds off until every verdict is in, then lets the pipe settle
  task automatic wait_for_verdicts();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write, then read back the same register
  task automatic program_reg(input logic [2:0] idx,
                             input logic [rcd_pkg::DATA_W-1:0] value);
    logic [rcd_pkg::DATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = sb.write_reg(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback) sb.flag("register readback", readback, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // the bus goes idle before the next transfer
    @(negedge clk);
  endtask

  task automatic set_region(input int left, input int top, input int width, input int height,
                            input int chan_thr, input int count_thr);
    program_reg(rcd_pkg::REG_LEFT, left);
    program_reg(rcd_pkg::REG_TOP, top);
    program_reg(rcd_pkg::REG_WIDTH, width);
    program_reg(rcd_pkg::REG_HEIGHT, height);
    program_reg(rcd_pkg::REG_CHAN_THR, chan_thr);
    program_reg(rcd_pkg::REG_COUNT_THR, count_thr);
  endtask

  // --------------------------------------------------------------------------
  // Random frames: raster scans of a small window around the region
  // --------------------------------------------------------------------------
  logic [rcd_pkg::PIX_W-1:0] scene [0:255];

  function automatic logic [rcd_pkg::CHAN_W-1:0] nudge(logic [rcd_pkg::CHAN_W-1:0] c,
                                                        int thr);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return rcd_pkg::CHAN_W'(v);
  endfunction

  function automatic logic [rcd_pkg::PIX_W-1:0] random_colour();
    return {rcd_pkg::CHAN_W'($urandom_range(0, 255)),
            rcd_pkg::CHAN_W'($urandom_range(0, 255)),
            rcd_pkg::CHAN_W'($urandom_range(0, 255))};
  endfunction

  task automatic send_frame();
    int x_lo, x_hi, y_lo, y_hi, k;
    bit done;
    pixel_t p;
    x_lo = (sb.left > 2) ? sb.left - 2 : 0;
    y_lo = (sb.top > 2) ? sb.top - 2 : 0;
    x_hi = sb.left + ((sb.width < 12) ? sb.width : 12) + 1;
    y_hi = sb.top + ((sb.height < 6) ? sb.height : 6) + 1;
    if (x_hi > 4095) x_hi = 4095;
    if (y_hi > 4095) y_hi = 4095;
    k = 0;
    done = 0;
    for (int yy = y_lo; yy <= y_hi && !done; yy++) begin
      for (int xx = x_lo; xx <= x_hi && !done; xx++) begin
        // stray beat with random coordinates and colour
        if ($urandom_range(0, 11) == 0) begin
          p = px($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
          push_pixel(p);
          random_pixels++;
        end
        if ($urandom_range(0, 7) == 0)
          scene[k] = random_colour();
        else
          scene[k] = {nudge(scene[k][23:16], sb.chan_thr), nudge(scene[k][15:8], sb.chan_thr),
                      nudge(scene[k][7:0], sb.chan_thr)};
        // frame cut short now and then
        done = (xx == x_hi && yy == y_hi) || ($urandom_range(0, 59) == 0);
        push_pixel(px(xx, yy, scene[k][23:16], scene[k][15:8], scene[k][7:0], done));
        random_pixels++;
        k++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int w, h, l, t;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: region edges, threshold boundary, frame end outside
    push_pixel(px(13, 152, 255, 255, 255, 0));
    push_pixel(px(12, 152, 255, 255, 255, 0));
    push_pixel(px(232, 152, 0, 0, 51, 0));
    push_pixel(px(233, 152, 9, 9, 9, 0));
    push_pixel(px(13, 184, 0, 0, 50, 0));
    push_pixel(px(13, 185, 7, 7, 7, 0));
    push_pixel(px(232, 151, 7, 7, 7, 0));
    push_pixel(px(4095, 4095, 255, 255, 255, 1));
    // second frame against the stored one, out-of-order coordinates
    push_pixel(px(13, 152, 205, 255, 255, 0));
    push_pixel(px(13, 152, 0, 0, 0, 0));
    push_pixel(px(13, 184, 255, 0, 0, 0));
    push_pixel(px(0, 0, 0, 0, 0, 1));
    // frame of one beat, frame end inside the region
    push_pixel(px(13, 152, 0, 0, 0, 1));
    wait_for_verdicts();

    // one-pixel region at the origin, zero thresholds
    set_region(0, 0, 1, 1, 0, 0);
    push_pixel(px(1, 0, 3, 3, 3, 0));
    push_pixel(px(0, 1, 3, 3, 3, 0));
    push_pixel(px(0, 0, 1, 0, 0, 1));
    wait_for_verdicts();

    // far corner with sizes of 4096, top thresholds
    set_region(4095, 4095, 4096, 4096, 255, 262143);
    push_pixel(px(4094, 4095, 0, 0, 0, 0));
    push_pixel(px(4095, 4094, 0, 0, 0, 0));
    push_pixel(px(4095, 4095, 255, 255, 255, 1));
    wait_for_verdicts();

    // empty region
    set_region(0, 0, 0, 1, 0, 0);
    push_pixel(px(0, 0, 200, 200, 200, 1));
    wait_for_verdicts();

    // random settings, a few frames each
    while (random_pixels < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 12);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0:       l = $urandom_range(0, 3);
        1:       l = 4095 - $urandom_range(0, 15);
        default: l = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 3))
        0:       t = $urandom_range(0, 3);
        1:       t = 4095 - $urandom_range(0, 15);
        default: t = $urandom_range(0, 4095);
      endcase
      set_region(l, t, w, h,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 40));
      foreach (scene[i])
        scene[i] = random_colour();
      repeat ($urandom_range(1, 4)) send_frame();
      wait_for_verdicts();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
design/rcd_pkg.sv
design/rcd_ram.sv
design/rcd_regs.sv
design/region_change_detector_unit.sv
verif/tb_top.sv
